FILE: rtl/sign_partition_negatives_first_defines.svh
// Assertion macros shared by the checker of the sign partition block.
// Depends on nothing; the using scope must provide clock and reset.
`ifndef SIGN_PARTITION_NEGATIVES_FIRST_DEFINES_SVH
`define SIGN_PARTITION_NEGATIVES_FIRST_DEFINES_SVH

// Property that must hold in the cycle after reset is seen
`define SPNF_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

// Property checked in the cycle after its trigger
`define SPNF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Property checked at the end of a trigger sequence
`define SPNF_ASSERT_SEQ(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spnf_pkg.sv
// Shared types and constants of the sign partition block.
// Used by the front, back, top level and checker; depends on nothing.
package spnf_pkg;

   localparam int VALUE_W       = 32;
   localparam int SWAP_W        = 7;
   localparam int DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH   = 4;
   localparam int OUT_DEPTH     = 4;

   // One input item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
   } req_type;

   // One result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [SWAP_W-1:0]         swap_total;
      logic                      overflowed;
      logic                      end_of_set;
   } rsp_type;

   // Classified item passed from front to back
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
      logic                      keep;        // element fits in the store
      logic                      overflowed;  // set has lost elements so far
   } ent_type;

   // Back-end sequencer
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS_RD,
      ST_PASS_EX,
      ST_PASS_WR,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/spnf_ram.sv
// Generic RAM: one write port and two read ports, read data registered.
// Depends on nothing.
module spnf_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write, then register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: rtl/spnf_fifo.sv
// Small register queue with occupancy count.
// Depends on nothing; used between front and back and on the result side.
module spnf_fifo #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Advance pointers with wrap, track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

FILE: rtl/spnf_front.sv
// Front end: accepts input items and classifies them as kept or dropped.
// Depends on spnf_pkg; feeds the front-to-back queue.
module spnf_front #(
   parameter int  DEPTH = spnf_pkg::DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  spnf_pkg::req_type req_data,
   output logic              req_full,
   output logic              q_push,
   output spnf_pkg::ent_type q_entry,
   input  logic              q_full
);

   import spnf_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             accept;
   logic             keep;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;
   assign keep     = (cnt_ff < CNT_W'(DEPTH));

   // Classify the accepted item
   assign q_push             = accept;
   assign q_entry.value      = req_data.value;
   assign q_entry.is_last    = req_data.is_last;
   assign q_entry.keep       = keep;
   assign q_entry.overflowed = ovf_ff | ~keep;

   // Count stored elements of the current set; drop the count on its last item
   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_data.is_last) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(keep);
            ovf_in = ovf_ff | ~keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

FILE: rtl/spnf_back.sv
// Back end: stores elements, runs the two-pointer pass and streams results.
// Depends on spnf_pkg and spnf_ram; drains the front queue, fills the result queue.
module spnf_back #(
   parameter int  DEPTH  = spnf_pkg::DEPTH_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1),
   localparam int OCNT_W = $clog2(spnf_pkg::OUT_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  spnf_pkg::ent_type q_entry,
   output logic              o_push,
   output spnf_pkg::rsp_type o_data,
   input  logic [OCNT_W-1:0] o_count
);

   import spnf_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [CNT_W-1:0]    wr_ff, wr_in;
   logic [CNT_W-1:0]    emit_ff, emit_in;
   logic [SWAP_W-1:0]   swap_ff, swap_in;
   logic                ovf_ff, ovf_in;
   logic [VALUE_W-1:0]  hold_ff, hold_in;
   logic                infl_ff, infl_in;
   logic                infl_last_ff, infl_last_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [VALUE_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]   rd_a_addr;
   logic [ADDR_W-1:0]   rd_b_addr;
   logic [VALUE_W-1:0]  rd_a_data;
   logic [VALUE_W-1:0]  rd_b_data;

   logic                pop_ok;
   logic                swap;
   logic                scan_done;
   logic                emit_done;
   logic                credit;
   logic                issue;

   spnf_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   // Port A follows the scan pointer, or the emit index while emitting
   assign rd_a_addr = (state_ff == ST_EMIT) ? emit_ff[ADDR_W-1:0] : scan_ff[ADDR_W-1:0];
   assign rd_b_addr = wr_ff[ADDR_W-1:0];

   assign pop_ok    = (state_ff == ST_LOAD) & ~q_empty;
   assign swap      = rd_a_data[VALUE_W-1] & ~rd_b_data[VALUE_W-1];
   assign scan_done = (CNT_W'(scan_ff + 1'b1) == load_cnt_ff);
   assign emit_done = (CNT_W'(emit_ff + 1'b1) == load_cnt_ff);

   // Issue a read only while the result queue has room for it and the one in flight
   assign credit = (({1'b0, o_count} + (OCNT_W + 1)'(infl_ff)) < (OCNT_W + 1)'(OUT_DEPTH));
   assign issue  = (state_ff == ST_EMIT) & credit;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (pop_ok && q_entry.is_last) begin
               state_in = ST_PASS_RD;
            end
         end
         ST_PASS_RD: begin
            state_in = ST_PASS_EX;
         end
         ST_PASS_EX: begin
            if (swap) begin
               state_in = ST_PASS_WR;
            end else if (scan_done) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PASS_RD;
            end
         end
         ST_PASS_WR: begin
            state_in = scan_done ? ST_EMIT : ST_PASS_RD;
         end
         ST_EMIT: begin
            if (issue && emit_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Datapath control per state
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      scan_in      = scan_ff;
      wr_in        = wr_ff;
      emit_in      = emit_ff;
      swap_in      = swap_ff;
      ovf_in       = ovf_ff;
      hold_in      = hold_ff;
      infl_in      = issue;
      infl_last_in = emit_done;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = wr_ff[ADDR_W-1:0];
      ram_wdata    = rd_a_data;
      unique case (state_ff)
         ST_LOAD: begin
            q_pop = ~q_empty;
            if (pop_ok) begin
               // store a kept element at the fill position
               if (q_entry.keep) begin
                  ram_we      = 1'b1;
                  ram_waddr   = load_cnt_ff[ADDR_W-1:0];
                  ram_wdata   = q_entry.value;
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
               // last item: arm the pass
               if (q_entry.is_last) begin
                  ovf_in  = q_entry.overflowed;
                  swap_in = '0;
                  scan_in = '0;
                  wr_in   = '0;
                  emit_in = '0;
               end
            end
         end
         ST_PASS_RD: begin
         end
         ST_PASS_EX: begin
            if (swap) begin
               // move the negative down, keep the displaced one for the next cycle
               ram_we    = 1'b1;
               ram_waddr = wr_ff[ADDR_W-1:0];
               ram_wdata = rd_a_data;
               hold_in   = rd_b_data;
               wr_in     = wr_ff + 1'b1;
               swap_in   = swap_ff + 1'b1;
            end else begin
               if (rd_b_data[VALUE_W-1]) begin
                  wr_in = wr_ff + 1'b1;
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_PASS_WR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[ADDR_W-1:0];
            ram_wdata = hold_ff;
            scan_in   = scan_ff + 1'b1;
         end
         ST_EMIT: begin
            if (issue) begin
               emit_in = emit_ff + 1'b1;
               if (emit_done) begin
                  load_cnt_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result leaves in the cycle after its read
   assign o_push            = infl_ff;
   assign o_data.value_out  = rd_a_data;
   assign o_data.swap_total = swap_ff;
   assign o_data.overflowed = ovf_ff;
   assign o_data.end_of_set = infl_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         scan_ff     <= '0;
         wr_ff       <= '0;
         emit_ff     <= '0;
         infl_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         scan_ff     <= scan_in;
         wr_ff       <= wr_in;
         emit_ff     <= emit_in;
         infl_ff     <= infl_in;
      end
   end

   always_ff @(posedge clock) begin
      swap_ff      <= swap_in;
      ovf_ff       <= ovf_in;
      hold_ff      <= hold_in;
      infl_last_ff <= infl_last_in;
   end

endmodule

FILE: rtl/sign_partition_negatives_first.sv
// Sign partition, negatives first. Elements arrive one per transfer and are
// stored in order until the transfer marked last; up to DEPTH elements are kept,
// further ones are dropped and the set is flagged as overflowed. The stored set
// is then reordered in place by a two-pointer pass that moves negative elements
// ahead of non-negative ones, and each element is returned in its new order with
// the swap count, the overflow flag and an end-of-set mark on the final one.
// Loading stores each kept element as it is popped from the front queue. Each
// step of the pass reads the scan and write positions of the element RAM, and a
// swap needs a second write state on the single write port of that RAM. The
// results stream out at one per cycle while the result queue has room. While a
// set is being reordered or emitted, up to QUEUE_DEPTH further input transfers
// are taken into the front queue. Reset needs no clearing of the element RAM.
module sign_partition_negatives_first #(
   parameter int DEPTH = spnf_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  spnf_pkg::req_type req_data,
   output logic              req_full,
   input  logic              rsp_pop,
   output spnf_pkg::rsp_type rsp_data,
   output logic              rsp_empty
);

   import spnf_pkg::*;

   localparam int ENT_W  = $bits(ent_type);
   localparam int RSP_W  = $bits(rsp_type);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   logic              q_push;
   ent_type           q_entry;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic [ENT_W-1:0]  q_head_bits;
   ent_type           q_head;
   logic              o_push;
   rsp_type           o_data;
   logic [OCNT_W-1:0] o_count;
   logic [RSP_W-1:0]  rsp_bits;

   // Accept and classify
   spnf_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_full   (q_full)
   );

   // Decouple front and back
   spnf_fifo #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_entry),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_head_bits),
      .empty (q_empty),
      .count ()
   );

   assign q_head = ent_type'(q_head_bits);

   // Store, partition and emit
   spnf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_entry (q_head),
      .o_push  (o_push),
      .o_data  (o_data),
      .o_count (o_count)
   );

   // Hold results until the consumer takes them
   spnf_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_results (
      .clock (clock),
      .reset (reset),
      .push  (o_push),
      .din   (o_data),
      .full  (),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .empty (rsp_empty),
      .count (o_count)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

FILE: rtl/spnf_checker.sv
// Port-level checks of the sign partition block, bound to its top level.
// Depends on spnf_pkg and the assertion macros header.
`include "sign_partition_negatives_first_defines.svh"

module spnf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_pop,
   input spnf_pkg::rsp_type rsp_data,
   input logic              rsp_empty
);

   // The result queue comes out of reset empty and the front queue not full
   `SPNF_ASSERT_AFTER_RESET(a_reset_empty, rsp_empty && !req_full, "queues not empty after reset")

   // A waiting result holds until it is taken
   `SPNF_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "result changed while stalled")

   // Swap count and overflow flag are the same across one set
   `SPNF_ASSERT_SEQ(a_set_fields, (!rsp_empty && rsp_pop && !rsp_data.end_of_set) ##1 (!rsp_empty), rsp_data.swap_total == $past(rsp_data.swap_total) && rsp_data.overflowed == $past(rsp_data.overflowed), "set fields differ within a set")

   // No negative element follows a non-negative one within a set
   `SPNF_ASSERT_SEQ(a_neg_first, (!rsp_empty && rsp_pop && !rsp_data.end_of_set && !rsp_data.value_out[31]) ##1 (!rsp_empty), !rsp_data.value_out[31], "negative after non-negative")

endmodule

bind sign_partition_negatives_first spnf_checker u_checker (.*);
